// ===== sv/rdb_pkg.sv =====
// Shared types and constants for the reconnect dialer.
// No dependencies; imported by every module of the block.
`default_nettype none
package rdb_pkg;
    localparam int CfgCount = 8;
    localparam int CfgIdxW  = 3;

    typedef enum logic [2:0] {
        CFG_BOOT_WAIT    = 3'd0,
        CFG_IDLE_WAIT    = 3'd1,
        CFG_NET_RETRY    = 3'd2,
        CFG_PRE_RETRY    = 3'd3,
        CFG_CONN_TIMEOUT = 3'd4,
        CFG_POLL_IVAL    = 3'd5,
        CFG_BACKOFF_MIN  = 3'd6,
        CFG_BACKOFF_MAX  = 3'd7
    } cfg_idx_t;

    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_WAITING    = 2'd1;
    localparam logic [1:0] PH_CONNECTING = 2'd2;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_REMOVED = 2'd1;
    localparam logic [1:0] MODE_ARRIVED = 2'd2;

    localparam logic [1:0] DIAL_CONNECTED = 2'd0;
    localparam logic [1:0] DIAL_PENDING   = 2'd1;
    localparam logic [1:0] POLL_PENDING   = 2'd0;
    localparam logic [1:0] POLL_CONNECTED = 2'd1;

    localparam logic [31:0] RST_BOOT_WAIT    = 32'd5000;
    localparam logic [31:0] RST_IDLE_WAIT    = 32'd5000;
    localparam logic [31:0] RST_NET_RETRY    = 32'd1000;
    localparam logic [31:0] RST_PRE_RETRY    = 32'd5000;
    localparam logic [31:0] RST_CONN_TIMEOUT = 32'd10000;
    localparam logic [31:0] RST_POLL_IVAL    = 32'd100;
    localparam logic [30:0] RST_BACKOFF_MIN  = 31'd1000;
    localparam logic [30:0] RST_BACKOFF_MAX  = 31'd300000;

    // x/5 == (x * RECIP5) >> 34 for any 32-bit x
    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
    localparam int DivSteps = 32;

    typedef struct packed {
        logic load;
        logic span_en;
        logic div_step;
        logic apply;
    } rdb_cmd_t;

    typedef struct packed {
        logic div_last;
    } rdb_status_t;
endpackage
`default_nettype wire

// ===== sv/reconnect_dialer_with_backoff.sv =====
// Top level of the reconnect dialer: joins controller and datapath.
// Depends on rdb_pkg, rdb_ctrl and rdb_datapath.
`default_nettype none
// Reconnect supervisor with exponential backoff and +/-20% jitter. One event
// beat in, one status beat out. The accept edge latches the event; then ST_SPAN
// does the backoff/5 reciprocal multiply, ST_DIV the bit-serial remainder of
// the random word by the jitter range, and ST_APPLY updates state and the result
// register, after which output valid rises. The next event is taken only in the
// cycle after the result beat is taken. The user must write config only while
// no event is in flight; the block itself does not enforce it.
module reconnect_dialer_with_backoff (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] now_ms, 32 target_client_present, 33 network_up, 34 preconditions_ok,
    // [36:35] dial_result, [38:37] poll_result, 39 handoff_accepted,
    // 40 conn_is_dialed, 41 session_authed, [73:42] random_value
    input  wire logic [79:0] s_tdata,
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] dial_state, [33:2] wait_ms, [64:34] backoff_ms, 65 session_live,
    // 66 dial_issued, 67 poll_issued, 68 handoff_issued, 69 release_socket
    output logic [71:0]      m_tdata
);
    import rdb_pkg::*;

    rdb_cmd_t    cmd;
    rdb_status_t status;

    rdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rdb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );
endmodule
`default_nettype wire

// ===== sv/rdb_datapath.sv =====
// Datapath: config registers, dialer state, jitter span and remainder unit,
// event evaluation and result register. Depends on rdb_pkg.
`default_nettype none
module rdb_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_addr,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic [79:0]         in_data,
    input  wire logic [1:0]          in_user,
    input  wire rdb_pkg::rdb_cmd_t   cmd,
    output rdb_pkg::rdb_status_t     status,
    output logic [71:0]              out_data
);
    import rdb_pkg::*;

    logic [31:0] boot_wait_reg, idle_wait_reg, net_retry_reg, pre_retry_reg;
    logic [31:0] conn_timeout_reg, poll_ival_reg;
    logic [30:0] backoff_min_reg, backoff_max_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic [31:0] last_poll_reg, last_poll_next;
    logic [31:0] cur_wait_reg, cur_wait_next;
    logic [30:0] backoff_reg, backoff_next;
    logic        tracked_reg, tracked_next;
    logic        sock_reg, sock_next;

    logic [79:0] ev_reg;
    logic [1:0]  mode_reg;
    logic [28:0] span_reg;
    logic [29:0] range_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [4:0]  cnt_reg;
    logic [71:0] out_reg;

    logic [62:0] prod;
    logic [31:0] trial;

    // latched event fields
    logic [31:0] now;
    logic        tgt_present, net_up, pre_ok, accepted, conn_dialed, was_auth;
    logic [1:0]  dial_res, poll_res;

    assign now         = ev_reg[31:0];
    assign tgt_present = ev_reg[32];
    assign net_up      = ev_reg[33];
    assign pre_ok      = ev_reg[34];
    assign dial_res    = ev_reg[36:35];
    assign poll_res    = ev_reg[38:37];
    assign accepted    = ev_reg[39];
    assign conn_dialed = ev_reg[40];
    assign was_auth    = ev_reg[41];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_wait_reg    <= RST_BOOT_WAIT;
            idle_wait_reg    <= RST_IDLE_WAIT;
            net_retry_reg    <= RST_NET_RETRY;
            pre_retry_reg    <= RST_PRE_RETRY;
            conn_timeout_reg <= RST_CONN_TIMEOUT;
            poll_ival_reg    <= RST_POLL_IVAL;
            backoff_min_reg  <= RST_BACKOFF_MIN;
            backoff_max_reg  <= RST_BACKOFF_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_BOOT_WAIT:    boot_wait_reg    <= cfg_wdata;
                CFG_IDLE_WAIT:    idle_wait_reg    <= cfg_wdata;
                CFG_NET_RETRY:    net_retry_reg    <= cfg_wdata;
                CFG_PRE_RETRY:    pre_retry_reg    <= cfg_wdata;
                CFG_CONN_TIMEOUT: conn_timeout_reg <= cfg_wdata;
                CFG_POLL_IVAL:    poll_ival_reg    <= cfg_wdata;
                CFG_BACKOFF_MIN:  backoff_min_reg  <= cfg_wdata[30:0];
                CFG_BACKOFF_MAX:  backoff_max_reg  <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // span = backoff / 5 through the reciprocal
    assign prod  = 63'(backoff_reg) * 63'(RECIP5);
    assign trial = {rem_reg[30:0], dvd_reg[31]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ev_reg   <= in_data;
            mode_reg <= in_user;
            dvd_reg  <= in_data[73:42];
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.span_en)
        begin
            span_reg  <= prod[62:34];
            range_reg <= {prod[62:34], 1'b1};
        end
        if (cmd.div_step)
        begin
            // restoring step, one remainder bit per cycle
            if (trial >= {2'b00, range_reg})
                rem_reg <= trial - {2'b00, range_reg};
            else
                rem_reg <= trial;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    assign status.div_last = (cnt_reg == 5'(DivSteps - 1));

    logic        f_dial, f_poll, f_handoff, f_release;
    logic        sched, retry, is_dialed;
    logic [31:0] sched_wait, retry_wait, doubled;

    always_comb
    begin
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        last_poll_next   = last_poll_reg;
        cur_wait_next    = cur_wait_reg;
        backoff_next     = backoff_reg;
        tracked_next     = tracked_reg;
        sock_next        = sock_reg;
        f_dial    = 1'b0;
        f_poll    = 1'b0;
        f_handoff = 1'b0;
        f_release = 1'b0;
        sched      = 1'b0;
        retry      = 1'b0;
        sched_wait = '0;
        is_dialed  = tracked_reg && conn_dialed;
        retry_wait = {1'b0, backoff_reg} - {3'b000, span_reg} + {2'b00, rem_reg[29:0]};
        doubled    = {backoff_reg, 1'b0};

        unique case (mode_reg)
            MODE_TICK:
            begin
                if (!tgt_present && !tracked_reg)
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            sched      = 1'b1;
                            sched_wait = idle_wait_reg;
                        end
                        PH_WAITING:
                        begin
                            if ((now - phase_start_reg) >= cur_wait_reg)
                            begin
                                priority if (!net_up)
                                begin
                                    sched      = 1'b1;
                                    sched_wait = net_retry_reg;
                                end
                                else if (!pre_ok)
                                begin
                                    sched      = 1'b1;
                                    sched_wait = pre_retry_reg;
                                end
                                else
                                begin
                                    f_dial    = 1'b1;
                                    sock_next = 1'b1;
                                    priority if (dial_res == DIAL_CONNECTED)
                                    begin
                                        f_handoff = 1'b1;
                                        sock_next = 1'b0;
                                        if (!accepted)
                                        begin
                                            sched      = 1'b1;
                                            sched_wait = pre_retry_reg;
                                        end
                                        else
                                        begin
                                            tracked_next = 1'b1;
                                            phase_next   = PH_IDLE;
                                        end
                                    end
                                    else if (dial_res == DIAL_PENDING)
                                    begin
                                        phase_next       = PH_CONNECTING;
                                        phase_start_next = now;
                                        last_poll_next   = now;
                                    end
                                    else
                                        retry = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            priority if ((now - phase_start_reg) >= conn_timeout_reg)
                                retry = 1'b1;
                            else if ((now - last_poll_reg) >= poll_ival_reg)
                            begin
                                last_poll_next = now;
                                f_poll         = 1'b1;
                                priority if (poll_res == POLL_PENDING)
                                    ;
                                else if (poll_res == POLL_CONNECTED)
                                begin
                                    f_handoff = 1'b1;
                                    sock_next = 1'b0;
                                    if (!accepted)
                                    begin
                                        sched      = 1'b1;
                                        sched_wait = pre_retry_reg;
                                    end
                                    else
                                    begin
                                        tracked_next = 1'b1;
                                        phase_next   = PH_IDLE;
                                    end
                                end
                                else
                                    retry = 1'b1;
                            end
                        end
                    endcase
                end
            end
            MODE_REMOVED:
            begin
                if (is_dialed)
                begin
                    tracked_next = 1'b0;
                    if (was_auth)
                        backoff_next = backoff_min_reg;
                    else
                        retry = 1'b1;
                end
            end
            MODE_ARRIVED:
            begin
                if (sock_reg)
                begin
                    f_release = 1'b1;
                    sock_next = 1'b0;
                end
                if (is_dialed)
                    tracked_next = 1'b0;
                phase_next   = PH_IDLE;
                backoff_next = backoff_min_reg;
            end
            default: ;
        endcase

        if (retry)
        begin
            sched        = 1'b1;
            sched_wait   = retry_wait;
            backoff_next = (doubled < {1'b0, backoff_max_reg}) ? doubled[30:0]
                                                               : backoff_max_reg;
        end
        if (sched)
        begin
            if (sock_next)
            begin
                f_release = 1'b1;
                sock_next = 1'b0;
            end
            phase_next       = PH_WAITING;
            phase_start_next = now;
            cur_wait_next    = sched_wait;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAITING;
            phase_start_reg <= '0;
            last_poll_reg   <= '0;
            cur_wait_reg    <= RST_BOOT_WAIT;
            backoff_reg     <= RST_BACKOFF_MIN;
            tracked_reg     <= 1'b0;
            sock_reg        <= 1'b0;
        end
        else if (cmd.apply)
        begin
            phase_reg       <= phase_next;
            phase_start_reg <= phase_start_next;
            last_poll_reg   <= last_poll_next;
            cur_wait_reg    <= cur_wait_next;
            backoff_reg     <= backoff_next;
            tracked_reg     <= tracked_next;
            sock_reg        <= sock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
            out_reg <= {2'b00, f_release, f_handoff, f_poll, f_dial, tracked_next,
                        backoff_next, cur_wait_next, phase_next};
    end

    assign out_data = out_reg;
endmodule
`default_nettype wire

// ===== sv/rdb_ctrl.sv =====
// Controller FSM: sequences load, span, remainder steps, update and output beat.
// Depends on rdb_pkg.
`default_nettype none
module rdb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire rdb_pkg::rdb_status_t status,
    output rdb_pkg::rdb_cmd_t         cmd
);
    import rdb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SPAN  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_OUT   = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.span_en  = 1'b0;
        cmd.div_step = 1'b0;
        cmd.apply    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                cmd.span_en = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire
